@@ hw/rtl/ipv4dq_pkg.sv @@
// ipv4dq_pkg: types, character codes and limits for the ipv4 dotted-quad parser
// no dependencies; used by every module of the block
package ipv4dq_pkg;

	localparam int MAX_CHARS_DEF = 15;
	localparam int MIN_CHARS     = 7;
	localparam int DOT_COUNT     = 3;
	localparam int OCTET_MAX     = 255;
	localparam int DEC_TEN       = 10;
	localparam int DEC_HUNDRED   = 100;
	localparam int TEXT_BITS     = 120;

	localparam logic [7:0] CHAR_DOT  = 8'h2E;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	// one input transfer
	typedef struct packed {
		logic [63:0] text_low;
		logic [55:0] text_high;
		logic [3:0]  text_length;
	} in_item_t;

	// one result transfer
	typedef struct packed {
		logic [31:0] address;
		logic        valid_res;
	} out_item_t;

	// per-character classification
	typedef struct packed {
		logic       act;
		logic       dig;
		logic       dot;
		logic       bad;
		logic [3:0] dval;
	} lane_t;

	// per-position field evaluation
	typedef struct packed {
		logic       fend;
		logic       dot;
		logic       err;
		logic [1:0] idx;
		logic [9:0] val;
	} field_t;

endpackage

@@ hw/rtl/ipv4_dotted_quad_parser_unit.sv @@
// ipv4_dotted_quad_parser_unit: top level of the dotted-decimal ipv4 address parser
// depends on ipv4dq_pkg, ipv4dq_lane, ipv4dq_field, ipv4dq_merge
//
// Takes one string of up to MAX_CHARS characters per transfer and returns one result per
// string: the 32-bit address (first octet in bits 31:24) and a valid flag, the address
// being zero when the flag is clear. A new string is taken every cycle while src_ready is
// high; each result passes through the three register stages (character lanes, per-position
// field evaluation, merge). src_ready drops only when all three stages hold a string and the
// result transfer is stalled. Characters past text_length are ignored.
module ipv4_dotted_quad_parser_unit #(
	parameter int MAX_CHARS = ipv4dq_pkg::MAX_CHARS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_ready,
	input  ipv4dq_pkg::in_item_t  src_item,
	output logic                  dst_valid,
	input  logic                  dst_ready,
	output ipv4dq_pkg::out_item_t dst_item
);

	localparam int NCH = MAX_CHARS;

	// stage valid flags and per-stage advance enables
	logic v1_q, v2_q, v3_q;
	logic en1, en2, en3;

	logic [ipv4dq_pkg::TEXT_BITS-1:0] text;
	logic [3:0]                       len_s1;
	logic [3:0]                       len_s2;

	ipv4dq_pkg::lane_t  lanes [NCH];
	// lanes padded with three empty positions in front and one behind
	ipv4dq_pkg::lane_t  pad   [NCH+4];
	logic [NCH-1:0]     dots;
	ipv4dq_pkg::field_t fields [NCH];

	// a stage advances when it is empty or the next one can take its content
	assign en3       = !v3_q || dst_ready;
	assign en2       = !v2_q || en3;
	assign en1       = !v1_q || en2;
	assign src_ready = en1;
	assign dst_valid = v3_q;

	assign text = {src_item.text_high, src_item.text_low};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= src_valid;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en3) begin
				v3_q <= v2_q;
			end
		end
	end

	// length travels alongside the lanes to the merge stage
	always_ff @(posedge clk) begin
		if (en1) begin
			len_s1 <= src_item.text_length;
		end
		if (en2) begin
			len_s2 <= len_s1;
		end
	end

	// stage 1: one classifying lane per character position
	for (genvar p = 0; p < NCH; p++) begin : g_lane
		ipv4dq_lane #(
			.POS(p)
		) u_lane (
			.clk     (clk),
			.en      (en1),
			.ch      (text[8*p +: 8]),
			.len     (src_item.text_length),
			.lane_s1 (lanes[p])
		);
	end

	always_comb begin
		for (int i = 0; i < NCH + 4; i++) begin
			pad[i] = '0;
		end
		for (int p = 0; p < NCH; p++) begin
			pad[p+3] = lanes[p];
			dots[p]  = lanes[p].dot;
		end
	end

	// stage 2: each position decides whether a field ends there and what it holds
	for (genvar p = 0; p < NCH; p++) begin : g_field
		ipv4dq_field #(
			.NCH (NCH),
			.POS (p)
		) u_field (
			.clk      (clk),
			.en       (en2),
			.p3       (pad[p]),
			.p2       (pad[p+1]),
			.p1       (pad[p+2]),
			.cur      (pad[p+3]),
			.nxt      (pad[p+4]),
			.dots     (dots),
			.field_s2 (fields[p])
		);
	end

	// stage 3: merge into the output register
	ipv4dq_merge #(
		.NCH       (NCH),
		.MAX_CHARS (MAX_CHARS)
	) u_merge (
		.clk       (clk),
		.en        (en3),
		.fields    (fields),
		.len       (len_s2),
		.result_s3 (dst_item)
	);

	// an invalid result never carries an address
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_item.valid_res |-> dst_item.address == '0)
		else $error("invalid result with nonzero address");

	// ready is withdrawn only when the whole pipeline is full
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!src_ready |-> v1_q && v2_q && v3_q && !dst_ready)
		else $error("ready low with room in the pipeline");

	// a new result appears only from an occupied middle stage
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v3_q) |-> $past(v2_q))
		else $error("result produced from an empty stage");

	// a stalled result transfer holds its value
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$past(dst_valid && !dst_ready) |-> $stable(dst_item))
		else $error("stalled result changed");

endmodule

@@ hw/rtl/ipv4dq_lane.sv @@
// ipv4dq_lane: classifies one character position and registers the result
// depends on ipv4dq_pkg
module ipv4dq_lane #(
	parameter int POS = 0
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [7:0]           ch,
	input  logic [3:0]           len,
	output ipv4dq_pkg::lane_t    lane_s1
);

	ipv4dq_pkg::lane_t lane_d;

	always_comb begin
		lane_d.act  = 4'(POS) < len;
		lane_d.dig  = lane_d.act && (ch >= ipv4dq_pkg::CHAR_ZERO) &&
			(ch <= ipv4dq_pkg::CHAR_NINE);
		lane_d.dot  = lane_d.act && (ch == ipv4dq_pkg::CHAR_DOT);
		lane_d.bad  = lane_d.act && !lane_d.dig && !lane_d.dot;
		lane_d.dval = ch[3:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s1 <= lane_d;
		end
	end

endmodule

@@ hw/rtl/ipv4dq_field.sv @@
// ipv4dq_field: evaluates the field that may end at one position, from a window of lanes
// depends on ipv4dq_pkg
module ipv4dq_field #(
	parameter int NCH = 15,
	parameter int POS = 0
) (
	input  logic               clk,
	input  logic               en,
	input  ipv4dq_pkg::lane_t  p3,
	input  ipv4dq_pkg::lane_t  p2,
	input  ipv4dq_pkg::lane_t  p1,
	input  ipv4dq_pkg::lane_t  cur,
	input  ipv4dq_pkg::lane_t  nxt,
	input  logic [NCH-1:0]     dots,
	output ipv4dq_pkg::field_t field_s2
);

	localparam logic [NCH-1:0] LOWER = NCH'((1 << POS) - 1);

	ipv4dq_pkg::field_t fd;
	logic [9:0]         d1;
	logic [9:0]         d2;

	always_comb begin
		d1 = p1.dig ? 10'(p1.dval) * 10'(ipv4dq_pkg::DEC_TEN) : '0;
		d2 = (p1.dig && p2.dig) ? 10'(p2.dval) * 10'(ipv4dq_pkg::DEC_HUNDRED) : '0;
		fd.fend = cur.dig && (!nxt.act || nxt.dot);
		fd.dot  = cur.dot;
		// stray character, empty field before a dot, trailing dot, four-digit run
		fd.err  = cur.bad || (cur.dot && !p1.dig) || (cur.dot && !nxt.act) ||
			(cur.dig && p1.dig && p2.dig && p3.dig);
		fd.idx  = 2'($countones(dots & LOWER));
		fd.val  = 10'(cur.dval) + d1 + d2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			field_s2 <= fd;
		end
	end

endmodule

@@ hw/rtl/ipv4dq_merge.sv @@
// ipv4dq_merge: combines the per-position fields into the address and valid flag
// depends on ipv4dq_pkg
module ipv4dq_merge #(
	parameter int NCH       = 15,
	parameter int MAX_CHARS = 15
) (
	input  logic                  clk,
	input  logic                  en,
	input  ipv4dq_pkg::field_t    fields [NCH],
	input  logic [3:0]            len,
	output ipv4dq_pkg::out_item_t result_s3
);

	logic [7:0]         oct [4];
	logic [NCH-1:0]     dotv;
	logic               any_err;
	logic               big;
	logic               len_ok;
	logic               ok;
	ipv4dq_pkg::out_item_t res;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			oct[k] = '0;
		end
		any_err = 1'b0;
		big     = 1'b0;
		for (int p = 0; p < NCH; p++) begin
			dotv[p] = fields[p].dot;
			any_err = any_err | fields[p].err;
			if (fields[p].fend) begin
				big = big | (fields[p].val > 10'(ipv4dq_pkg::OCTET_MAX));
				oct[fields[p].idx] = oct[fields[p].idx] | fields[p].val[7:0];
			end
		end
		len_ok = (len >= 4'(ipv4dq_pkg::MIN_CHARS)) && ({1'b0, len} <= 5'(MAX_CHARS));
		ok = len_ok && !any_err && !big &&
			(5'($countones(dotv)) == 5'(ipv4dq_pkg::DOT_COUNT));
		res.valid_res = ok;
		res.address   = ok ? {oct[0], oct[1], oct[2], oct[3]} : '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_s3 <= res;
		end
	end

endmodule
